// ===== src/tfr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, field types and pipeline stage structs of the triangle fill rasterizer
// no dependencies
package tfr_pkg;

  localparam int COORD_W = 18;                    // vertex coordinate width
  localparam int FRAC_W  = 4;                     // fraction bits of a coordinate
  localparam int POS_W   = COORD_W - FRAC_W;      // integer scan position width
  localparam int EDGE_W  = COORD_W + 1;           // edge vector and offset width
  localparam int PROD_W  = 2 * EDGE_W;            // one cross product term
  localparam int CROSS_W = PROD_W + 3;            // room for d - s - t
  localparam int RGB_W   = 24;
  localparam int DIM_W   = 13;                    // screen size registers
  localparam int CFG_IDX_W = 1;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [EDGE_W-1:0] HALF_PIX =
    EDGE_W'((FRAC_W > 0) ? (1 << (FRAC_W - 1)) : 0);
  localparam logic [DIM_W-1:0] SCREEN_RESET = DIM_W'(300);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_index_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } command_e;

  // scan position plus everything the inside test needs
  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [RGB_W-1:0]         rgb;
    logic                     on_screen;
    logic                     last;
    logic signed [EDGE_W-1:0] qx;
    logic signed [EDGE_W-1:0] qy;
    logic signed [EDGE_W-1:0] ea_x;
    logic signed [EDGE_W-1:0] ea_y;
    logic signed [EDGE_W-1:0] eb_x;
    logic signed [EDGE_W-1:0] eb_y;
  } setup_t;

  // registered cross product terms
  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [RGB_W-1:0]         rgb;
    logic                     on_screen;
    logic                     last;
    logic signed [PROD_W-1:0] qx_eby;
    logic signed [PROD_W-1:0] qy_ebx;
    logic signed [PROD_W-1:0] eax_qy;
    logic signed [PROD_W-1:0] eay_qx;
    logic signed [PROD_W-1:0] eax_eby;
    logic signed [PROD_W-1:0] eay_ebx;
  } prod_t;

endpackage

// ===== src/triangle_fill_rasterizer_core.sv =====
`timescale 1ns / 1ps
// top level of the triangle fill rasterizer: config registers and the three stage pipeline
// depends on tfr_pkg, tfr_scan, tfr_mul, tfr_test
//
// A load word (command 0) latches three vertices (signed, 4 fraction bits) and a fill color,
// sets up the bounding box and restarts the scan; it produces no output word. Each tick word
// (command 1) visits one box position, x outer and y inner, and produces one output word with
// the position, the color, a write flag (inside the triangle and on screen) and a last flag.
// Ticks while idle or after the last position, and any tick of an empty box, are taken and
// dropped. One word is accepted per cycle unless the pipe stalls; a tick's result passes the
// scan register, the product register and the output register before it reaches the output.
// Each stage holds its word until the next one frees up, so while a result waits the pipe
// takes at most two more ticks before the input stalls. The cost of a position is set by six
// 19x19 signed multipliers in the middle stage. Screen size is set through the write port;
// the user must change it only while no scan words are in flight (the block does not enforce it).
module triangle_fill_rasterizer_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tfr_pkg::DIM_W-1:0]            cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v1_x_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v1_y_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v2_x_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v2_y_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v3_x_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v3_y_i,
  input  logic [tfr_pkg::RGB_W-1:0]            fill_rgb_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tfr_pkg::POS_W-1:0]     pixel_x_o,
  output logic signed [tfr_pkg::POS_W-1:0]     pixel_y_o,
  output logic [tfr_pkg::RGB_W-1:0]            pixel_rgb_o,
  output logic                                 write_enable_o,
  output logic                                 last_o
);

  // screen size, both reset to 300
  logic [tfr_pkg::DIM_W-1:0] screen_width_q, screen_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= tfr_pkg::SCREEN_RESET;
      screen_height_q <= tfr_pkg::SCREEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tfr_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        tfr_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake: each stage moves when its downstream is free
  logic            stg_valid, mul_free, prod_valid, test_free;
  tfr_pkg::setup_t stg;
  tfr_pkg::prod_t  prod;

  // setup, box and scan counters, first register
  tfr_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .v1_x_i          (v1_x_i),
    .v1_y_i          (v1_y_i),
    .v2_x_i          (v2_x_i),
    .v2_y_i          (v2_y_i),
    .v3_x_i          (v3_x_i),
    .v3_y_i          (v3_y_i),
    .fill_rgb_i      (fill_rgb_i),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .down_free_i     (mul_free),
    .stg_valid_o     (stg_valid),
    .stg_o           (stg)
  );

  // cross product terms
  tfr_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stg_valid_i  (stg_valid),
    .stg_i        (stg),
    .down_free_i  (test_free),
    .free_o       (mul_free),
    .prod_valid_o (prod_valid),
    .prod_o       (prod)
  );

  // sign test and output register
  tfr_test u_test (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .prod_valid_i   (prod_valid),
    .prod_i         (prod),
    .free_o         (test_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_rgb_o    (pixel_rgb_o),
    .write_enable_o (write_enable_o),
    .last_o         (last_o)
  );

endmodule

// ===== src/tfr_scan.sv =====
`timescale 1ns / 1ps
// triangle setup, bounding box scan state and the first pipeline register
// depends on tfr_pkg
module tfr_scan (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v1_x_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v1_y_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v2_x_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v2_y_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v3_x_i,
  input  logic signed [tfr_pkg::COORD_W-1:0]   v3_y_i,
  input  logic [tfr_pkg::RGB_W-1:0]            fill_rgb_i,
  input  logic [tfr_pkg::DIM_W-1:0]            screen_width_i,
  input  logic [tfr_pkg::DIM_W-1:0]            screen_height_i,
  input  logic                                 down_free_i,
  output logic                                 stg_valid_o,
  output tfr_pkg::setup_t                      stg_o
);

  localparam int CW = tfr_pkg::COORD_W;
  localparam int EW = tfr_pkg::EDGE_W;
  localparam int PW = tfr_pkg::POS_W;
  localparam int FW = tfr_pkg::FRAC_W;

  // integer part rounded toward zero
  function automatic logic signed [PW-1:0] trunc_pos(input logic signed [CW-1:0] v);
    logic [EW-1:0] mag;
    logic [EW-1:0] sh;
    mag = v[CW-1] ? EW'(-$signed({v[CW-1], v})) : EW'($signed({v[CW-1], v}));
    sh  = mag >> FW;
    trunc_pos = v[CW-1] ? PW'(-$signed(sh)) : PW'(sh);
  endfunction

  // floor(v + 0.5), saturated to the top position
  function automatic logic signed [PW-1:0] upper_pos(input logic signed [CW-1:0] v);
    logic signed [EW-1:0] s;
    logic signed [EW-1:0] f;
    s = $signed({v[CW-1], v}) + tfr_pkg::HALF_PIX;
    f = s >>> FW;
    upper_pos = (f > EW'(tfr_pkg::POS_MAX)) ? tfr_pkg::POS_MAX : PW'(f);
  endfunction

  logic signed [CW-1:0] anchor_x_q, anchor_y_q;
  logic signed [EW-1:0] ea_x_q, ea_y_q, eb_x_q, eb_y_q;
  logic signed [PW-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;
  logic signed [PW-1:0] scan_x_q, scan_y_q;
  logic [tfr_pkg::RGB_W-1:0] fill_q;
  logic active_q;
  logic stg_valid_q;
  tfr_pkg::setup_t stg_q, stg_d;

  logic free, accept, load, tick;
  logic signed [CW-1:0] mn_x, mx_x, mn_y, mx_y;
  logic signed [PW-1:0] x_lo_d, x_hi_d, y_lo_d, y_hi_d;
  logic fin;

  assign free       = !stg_valid_q || down_free_i;
  assign in_ready_o = free;
  assign accept     = in_valid_i && free;
  assign load       = accept && (command_i == tfr_pkg::CMD_LOAD);
  assign tick       = accept && (command_i == tfr_pkg::CMD_TICK) && active_q;

  always_comb begin
    mn_x = v1_x_i;
    mx_x = v1_x_i;
    mn_y = v1_y_i;
    mx_y = v1_y_i;
    if (v2_x_i < mn_x) mn_x = v2_x_i;
    if (v3_x_i < mn_x) mn_x = v3_x_i;
    if (v2_x_i > mx_x) mx_x = v2_x_i;
    if (v3_x_i > mx_x) mx_x = v3_x_i;
    if (v2_y_i < mn_y) mn_y = v2_y_i;
    if (v3_y_i < mn_y) mn_y = v3_y_i;
    if (v2_y_i > mx_y) mx_y = v2_y_i;
    if (v3_y_i > mx_y) mx_y = v3_y_i;
  end

  assign x_lo_d = trunc_pos(mn_x);
  assign x_hi_d = upper_pos(mx_x);
  assign y_lo_d = trunc_pos(mn_y);
  assign y_hi_d = upper_pos(mx_y);

  assign fin = (scan_x_q == x_hi_q) && (scan_y_q == y_hi_q);

  always_comb begin
    stg_d.x    = scan_x_q;
    stg_d.y    = scan_y_q;
    stg_d.rgb  = fill_q;
    stg_d.last = fin;
    stg_d.on_screen = !scan_x_q[PW-1] && !scan_y_q[PW-1] &&
                      (scan_x_q[PW-2:0] < screen_width_i) &&
                      (scan_y_q[PW-2:0] < screen_height_i);
    // position in fixed point minus the anchor
    stg_d.qx   = $signed({scan_x_q[PW-1], scan_x_q, {FW{1'b0}}})
               - $signed({anchor_x_q[CW-1], anchor_x_q});
    stg_d.qy   = $signed({scan_y_q[PW-1], scan_y_q, {FW{1'b0}}})
               - $signed({anchor_y_q[CW-1], anchor_y_q});
    stg_d.ea_x = ea_x_q;
    stg_d.ea_y = ea_y_q;
    stg_d.eb_x = eb_x_q;
    stg_d.eb_y = eb_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      ea_x_q     <= '0;
      ea_y_q     <= '0;
      eb_x_q     <= '0;
      eb_y_q     <= '0;
      x_lo_q     <= '0;
      x_hi_q     <= '0;
      y_lo_q     <= '0;
      y_hi_q     <= '0;
      scan_x_q   <= '0;
      scan_y_q   <= '0;
      fill_q     <= '0;
      active_q   <= 1'b0;
    end else if (load) begin
      anchor_x_q <= v1_x_i;
      anchor_y_q <= v1_y_i;
      ea_x_q     <= $signed({v2_x_i[CW-1], v2_x_i}) - $signed({v1_x_i[CW-1], v1_x_i});
      ea_y_q     <= $signed({v2_y_i[CW-1], v2_y_i}) - $signed({v1_y_i[CW-1], v1_y_i});
      eb_x_q     <= $signed({v3_x_i[CW-1], v3_x_i}) - $signed({v1_x_i[CW-1], v1_x_i});
      eb_y_q     <= $signed({v3_y_i[CW-1], v3_y_i}) - $signed({v1_y_i[CW-1], v1_y_i});
      x_lo_q     <= x_lo_d;
      x_hi_q     <= x_hi_d;
      y_lo_q     <= y_lo_d;
      y_hi_q     <= y_hi_d;
      scan_x_q   <= x_lo_d;
      scan_y_q   <= y_lo_d;
      fill_q     <= fill_rgb_i;
      active_q   <= (x_lo_d <= x_hi_d) && (y_lo_d <= y_hi_d);
    end else if (tick) begin
      if (fin) begin
        active_q <= 1'b0;
      end else if (scan_y_q >= y_hi_q) begin
        scan_y_q <= y_lo_q;
        scan_x_q <= scan_x_q + PW'(1);
      end else begin
        scan_y_q <= scan_y_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (free) begin
      stg_valid_q <= tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      stg_q <= stg_d;
    end
  end

  assign stg_valid_o = stg_valid_q;
  assign stg_o       = stg_q;

endmodule

// ===== src/tfr_mul.sv =====
`timescale 1ns / 1ps
// cross product multiplier stage, six parallel products then a register
// depends on tfr_pkg
module tfr_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            stg_valid_i,
  input  tfr_pkg::setup_t stg_i,
  input  logic            down_free_i,
  output logic            free_o,
  output logic            prod_valid_o,
  output tfr_pkg::prod_t  prod_o
);

  logic           valid_q;
  logic           take;
  tfr_pkg::prod_t prod_q, prod_d;

  assign free_o = !valid_q || down_free_i;
  assign take   = stg_valid_i && free_o;

  always_comb begin
    prod_d.x         = stg_i.x;
    prod_d.y         = stg_i.y;
    prod_d.rgb       = stg_i.rgb;
    prod_d.on_screen = stg_i.on_screen;
    prod_d.last      = stg_i.last;
    prod_d.qx_eby    = $signed(stg_i.qx)   * $signed(stg_i.eb_y);
    prod_d.qy_ebx    = $signed(stg_i.qy)   * $signed(stg_i.eb_x);
    prod_d.eax_qy    = $signed(stg_i.ea_x) * $signed(stg_i.qy);
    prod_d.eay_qx    = $signed(stg_i.ea_y) * $signed(stg_i.qx);
    prod_d.eax_eby   = $signed(stg_i.ea_x) * $signed(stg_i.eb_y);
    prod_d.eay_ebx   = $signed(stg_i.ea_y) * $signed(stg_i.eb_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= stg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = valid_q;
  assign prod_o       = prod_q;

endmodule

// ===== src/tfr_test.sv =====
`timescale 1ns / 1ps
// sign test of the barycentric cross products and the output register
// depends on tfr_pkg
module tfr_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               prod_valid_i,
  input  tfr_pkg::prod_t                     prod_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tfr_pkg::POS_W-1:0]   pixel_x_o,
  output logic signed [tfr_pkg::POS_W-1:0]   pixel_y_o,
  output logic [tfr_pkg::RGB_W-1:0]          pixel_rgb_o,
  output logic                               write_enable_o,
  output logic                               last_o
);

  localparam int XW = tfr_pkg::CROSS_W;

  logic signed [XW-1:0] det, s_val, t_val, r_val;
  logic ok_s, ok_t, ok_r, hit;
  logic take;

  logic                             valid_q;
  logic signed [tfr_pkg::POS_W-1:0] x_q, y_q;
  logic [tfr_pkg::RGB_W-1:0]        rgb_q;
  logic                             we_q, last_q;

  assign free_o = !valid_q || out_ready_i;
  assign take   = prod_valid_i && free_o;

  always_comb begin
    det   = XW'(prod_i.eax_eby) - XW'(prod_i.eay_ebx);
    s_val = XW'(prod_i.qx_eby)  - XW'(prod_i.qy_ebx);
    t_val = XW'(prod_i.eax_qy)  - XW'(prod_i.eay_qx);
    r_val = det - s_val - t_val;
    // each term zero or on the same side as the determinant
    ok_s  = (s_val == '0) || (s_val[XW-1] == det[XW-1]);
    ok_t  = (t_val == '0) || (t_val[XW-1] == det[XW-1]);
    ok_r  = (r_val == '0) || (r_val[XW-1] == det[XW-1]);
    hit   = (det != '0) && ok_s && ok_t && ok_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q    <= prod_i.x;
      y_q    <= prod_i.y;
      rgb_q  <= prod_i.rgb;
      we_q   <= prod_i.on_screen && hit;
      last_q <= prod_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign pixel_x_o      = x_q;
  assign pixel_y_o      = y_q;
  assign pixel_rgb_o    = rgb_q;
  assign write_enable_o = we_q;
  assign last_o         = last_q;

endmodule

// ===== src/tfr_checker.sv =====
`timescale 1ns / 1ps
// port level checks of the triangle fill rasterizer, bound to the top level
// depends on tfr_pkg and triangle_fill_rasterizer_core
module tfr_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [tfr_pkg::POS_W-1:0]     pixel_x_o,
  input logic signed [tfr_pkg::POS_W-1:0]     pixel_y_o,
  input logic [tfr_pkg::RGB_W-1:0]            pixel_rgb_o,
  input logic                                 write_enable_o,
  input logic                                 last_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o)
      && $stable(pixel_rgb_o) && $stable(write_enable_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no output pending");

  // a written pixel is never left or above the screen
  a_write_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> !pixel_x_o[tfr_pkg::POS_W-1] &&
      !pixel_y_o[tfr_pkg::POS_W-1])
    else $error("write at negative position");

  // nothing comes out right after reset, the pipeline starts empty
  a_no_early_output: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output word right after reset");

endmodule

bind triangle_fill_rasterizer_core tfr_checker u_tfr_checker (.*);
